FILE: rtl/core/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the balance
// block codec.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BAL_W     = 16;
  localparam int unsigned DATA_W    = LANES * BYTE_W;
  localparam int unsigned CHECK_W   = 16;
  localparam int unsigned LANE_STEP = 9;
  localparam int unsigned S2_BYTES  = 5;   // bytes folded into the CRC in stage 2

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef struct packed {
    logic                 op;
    logic [BAL_W-1:0]     balance;
    logic [DATA_W-1:0]    data_bytes;
    logic [CHECK_W-1:0]   check_bytes;
  } in_t;

  typedef struct packed {
    logic [BAL_W-1:0]     balance_out;
    logic                 crc_ok;
    logic [DATA_W-1:0]    block_data;
    logic [CHECK_W-1:0]   block_check;
  } out_t;

  // Mapped beat after the lanes: block bytes and the balance the lanes read
  // back out of them.
  typedef struct packed {
    op_t                  op;
    logic [DATA_W-1:0]    bytes;
    logic [CHECK_W-1:0]   check;
    logic [BAL_W-1:0]     bal;
  } s1_t;

  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (a[0]) begin
        a = (a >> 1) ^ CRC_POLY;
      end else begin
        a = a >> 1;
      end
    end
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bbc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_lane
// One byte lane: maps a balance bit pair to its block byte and a block byte
// back to its bit pair.
// ----------------------------------------------------------------------------
module bbc_lane (
  input  wire logic [1:0] pair_in,   // [1] higher balance bit, [0] lower
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] ofs,
  output logic      [7:0] enc_byte,
  output logic      [1:0] dec_pair   // [1] higher balance bit, [0] lower
);
  import bbc_pkg::*;

  logic [7:0] code;
  logic [7:0] plain;

  // code bit 0 carries the higher bit of the pair
  assign code     = {6'b0, pair_in[0], pair_in[1]};
  assign enc_byte = ~(code + ofs);

  assign plain    = (~byte_in) - ofs;
  assign dec_pair = {plain[0], plain[1]};

endmodule
`default_nettype wire

FILE: rtl/core/bbc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_merge
// Merging stage: CRC over the lane bytes in two registered halves, CRC check
// on decode and the output register.
// ----------------------------------------------------------------------------
module bbc_merge (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          s1_valid,
  input  wire bbc_pkg::s1_t  s1_data,
  output logic               s1_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bbc_pkg::out_t      out_data
);
  import bbc_pkg::*;

  logic        v2_r, v2_nxt;
  s1_t         s2_r;
  logic [15:0] acc2_r, acc2_nxt;
  logic        vo_r, vo_nxt;
  out_t        out_r, out_nxt;
  logic        ld2, ld3;
  logic [15:0] crc_data;
  logic [15:0] crc_full;

  assign ld3      = v2_r && (!vo_r || !out_stall);
  assign s1_ready = !v2_r || ld3;
  assign ld2      = s1_valid && s1_ready;

  // first half of the CRC: bytes 0..4
  always_comb begin
    acc2_nxt = CRC_INIT;
    for (int i = 0; i < S2_BYTES; i++) begin
      acc2_nxt = crc_byte(acc2_nxt, s1_data.bytes[i*BYTE_W +: BYTE_W]);
    end
  end

  // second half: bytes 5..7, then the two check bytes for decode
  always_comb begin
    crc_data = acc2_r;
    for (int i = S2_BYTES; i < LANES; i++) begin
      crc_data = crc_byte(crc_data, s2_r.bytes[i*BYTE_W +: BYTE_W]);
    end
    crc_full = crc_byte(crc_byte(crc_data, s2_r.check[7:0]), s2_r.check[15:8]);
  end

  always_comb begin
    out_nxt = '0;
    unique case (s2_r.op)
      OP_ENCODE: begin
        out_nxt.crc_ok      = 1'b1;
        out_nxt.block_data  = s2_r.bytes;
        out_nxt.block_check = crc_data;
      end
      OP_DECODE: begin
        out_nxt.crc_ok      = (crc_full == 16'h0000);
        out_nxt.balance_out = (crc_full == 16'h0000) ? s2_r.bal : '0;
      end
      default: out_nxt = '0;
    endcase
  end

  always_comb begin
    v2_nxt = v2_r;
    if (ld2) begin
      v2_nxt = 1'b1;
    end else if (ld3) begin
      v2_nxt = 1'b0;
    end
    vo_nxt = vo_r;
    if (ld3) begin
      vo_nxt = 1'b1;
    end else if (!out_stall) begin
      vo_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_r   <= s1_data;
      acc2_r <= acc2_nxt;
    end
    if (ld3) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/balance_block_codec_crc16_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balance_block_codec_crc16_core
// Stored-value balance block codec with CRC-16/Modbus.
//
// Encode (op = 0) spreads the 16-bit balance over eight block bytes, two bits
// per byte with a per-byte offset of 9*i and inversion, and appends the
// CRC-16/Modbus of those bytes (low byte first in block_check). Decode
// (op = 1) checks the CRC over all ten bytes; on a good check the balance is
// recovered and crc_ok is set, otherwise balance_out is zero and crc_ok
// clear. On decode block_data and block_check are zero; on encode
// balance_out is zero and crc_ok is one. The constant 0xFF pad bytes of the
// card block are not carried. Throughput is one beat per clock while the
// output is not stalled. There are three register stages: stage 1 runs
// eight byte lanes in parallel, stages 2 and 3 split the 80-bit CRC fold
// into halves, the last one being the output register. A stalled output
// only backs up the pipeline once every stage holds a beat. No
// configuration, no state between beats.
// ----------------------------------------------------------------------------
module balance_block_codec_crc16_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bbc_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bbc_pkg::out_t       out_data
);
  import bbc_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  s1_t               s1_r, s1_nxt;
  logic              s1_ready;
  logic              ld1;
  logic [DATA_W-1:0] enc_bytes;
  logic [BAL_W-1:0]  dec_bal;

  // Byte lanes: lane i owns balance bits 15-2i and 14-2i and block byte i.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    bbc_lane u_lane (
      .pair_in  (in_data.balance[BAL_W-1-2*i -: 2]),
      .byte_in  (in_data.data_bytes[i*BYTE_W +: BYTE_W]),
      .ofs      (8'(i * LANE_STEP)),
      .enc_byte (enc_bytes[i*BYTE_W +: BYTE_W]),
      .dec_pair (dec_bal[BAL_W-1-2*i -: 2])
    );
  end

  // stage 1 register holds the block bytes that go through the CRC:
  // freshly encoded ones, or the received ones on decode
  always_comb begin
    s1_nxt.op    = op_t'(in_data.op);
    s1_nxt.check = in_data.check_bytes;
    s1_nxt.bal   = dec_bal;
    unique case (op_t'(in_data.op))
      OP_ENCODE: s1_nxt.bytes = enc_bytes;
      OP_DECODE: s1_nxt.bytes = in_data.data_bytes;
      default:   s1_nxt.bytes = enc_bytes;
    endcase
  end

  assign in_stall = s1_valid_r && !s1_ready;
  assign ld1      = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ld1) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= s1_nxt;
    end
  end

  // CRC merge and output register
  bbc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_data   (s1_r),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: bench/balance_block_codec_crc16_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance_block_codec_crc16_core_tb
// Self-checking bench for the balance block codec. It encodes and decodes
// balances with a bit-serial CRC-16/Modbus predictor of its own, and matches
// every output beat in order against the predicted block or balance. Random
// gaps on both channels and one long output hold-off exercise the handshake.
// ----------------------------------------------------------------------------
module balance_block_codec_crc16_core_tb;
  import bbc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 60;    // receiver hold-off for the fill test
  localparam int IDLE_LIMIT   = 2000;  // cycles without any accepted beat
  localparam int DRAIN_CYCLES = 10;    // pipeline is three deep
  localparam int RANDOM_ITEMS = 750;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Predicted result beats, oldest first
  out_t expected_results[$];

  // Knobs shared between the stimulus and the receiver
  logic hold_req;
  logic quiet_tx;
  logic quiet_rx;

  int n_fail;
  int n_encode;
  int n_decode;
  int n_good_crc;
  int n_results;
  int n_in_stalled;
  int idle_cycles;

  balance_block_codec_crc16_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Reflected CRC run one bit at a time over n_bytes bytes, byte 0 in bits 7:0,
  // so walking the vector from bit 0 upwards is the wire order.
  function automatic logic [15:0] modbus_crc(logic [79:0] bytes_le, int n_bytes);
    logic [15:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < n_bytes * 8; i++) begin
      fb  = crc[0] ^ bytes_le[i];
      crc = {1'b0, crc[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

  // Pair i of the balance (MSB pair first) lands in byte i, bits swapped,
  // offset by 9*i and inverted.
  function automatic logic [63:0] spread_balance(logic [15:0] bal);
    logic [63:0] blk;
    logic [7:0]  code;
    for (int i = 0; i < 8; i++) begin
      code = {6'd0, bal[14-2*i], bal[15-2*i]};
      blk[8*i +: 8] = ~(code + 8'(i * LANE_STEP));
    end
    return blk;
  endfunction

  function automatic out_t codec_predict(in_t item);
    out_t       r;
    logic [7:0] code;
    r = '0;
    if (item.op == OP_ENCODE) begin
      r.crc_ok      = 1'b1;
      r.block_data  = spread_balance(item.balance);
      r.block_check = modbus_crc({16'h0000, r.block_data}, 8);
    end else if (modbus_crc({item.check_bytes, item.data_bytes}, 10) == 16'h0000) begin
      // Good residue: undo inversion and offset, only bits 1:0 matter
      r.crc_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
        code = ~item.data_bytes[8*i +: 8] - 8'(i * LANE_STEP);
        r.balance_out[15-2*i] = code[0];
        r.balance_out[14-2*i] = code[1];
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Encode beat; the block fields are ignored, so fill them with junk
  function automatic in_t make_encode(logic [15:0] bal);
    in_t it;
    it.op          = OP_ENCODE;
    it.balance     = bal;
    it.data_bytes  = rand64();
    it.check_bytes = 16'($urandom);
    return it;
  endfunction

  // Decode beat; balance is ignored, so it carries junk
  function automatic in_t make_decode(logic [63:0] data, logic [15:0] check);
    in_t it;
    it.op          = OP_DECODE;
    it.balance     = 16'($urandom);
    it.data_bytes  = data;
    it.check_bytes = check;
    return it;
  endfunction

  // Decode beat whose CRC is right for the given data bytes
  function automatic in_t make_sealed(logic [63:0] data);
    return make_decode(data, modbus_crc({16'h0000, data}, 8));
  endfunction

  function automatic in_t random_item();
    in_t         it;
    logic [15:0] bal;
    logic [79:0] blk;
    int          kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      bal = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      bal = 16'($urandom);
    end
    if (kind < 35) begin
      it = make_encode(bal);
    end else if (kind < 55) begin
      it = make_sealed(spread_balance(bal));        // clean round trip
    end else if (kind < 75) begin
      it = make_sealed(rand64());                   // good CRC, junk upper bits
    end else if (kind < 88) begin
      it  = make_sealed(spread_balance(bal));       // single bit corrupted
      blk = {it.check_bytes, it.data_bytes} ^ (80'd1 << $urandom_range(0, 79));
      {it.check_bytes, it.data_bytes} = blk;
    end else begin
      it = make_decode(rand64(), 16'($urandom));    // noise, almost always bad
    end
    return it;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one beat per call. Valid is left high after acceptance so that a
  // back-to-back beat needs no second assignment in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_t item);
    int gap;
    gap = quiet_tx ? 0 : pause_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(codec_predict(item));
    if (item.op == OP_ENCODE) begin
      n_encode++;
    end else begin
      n_decode++;
      if (expected_results[$].crc_ok) n_good_crc++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off counted here when requested
  // --------------------------------------------------------------------------
  initial begin : rx_throttle
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && !quiet_rx) stall_left = pause_len();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: each accepted beat against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        check_field("balance_out", want.balance_out, out_data.balance_out);
        check_field("crc_ok",      want.crc_ok,      out_data.crc_ok);
        check_field("block_data",  want.block_data,  out_data.block_data);
        check_field("block_check", want.block_check, out_data.block_check);
      end
    end
  end

  // Watchdog on handshake progress; also counts cycles the input was held back
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) n_in_stalled++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("** balance_block_codec_crc16_core: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Balance extremes and alternating pairs, junk in the unused block fields
  task automatic test_encode_corners();
    in_t it;
    send_item(make_encode(16'h0000));
    send_item(make_encode(16'hFFFF));
    send_item(make_encode(16'h8000));
    send_item(make_encode(16'h4000));
    send_item(make_encode(16'h0001));
    send_item(make_encode(16'h5555));
    send_item(make_encode(16'hAAAA));
    it = make_encode(16'h1234);
    it.data_bytes  = '1;
    it.check_bytes = '1;
    send_item(it);
  endtask

  // Round trips, good CRC with junk upper bits, and CRC failures
  task automatic test_decode_corners();
    in_t it;
    send_item(make_sealed(spread_balance(16'h0000)));
    send_item(make_sealed(spread_balance(16'hFFFF)));
    send_item(make_sealed(spread_balance(16'hA5C3)));
    send_item(make_sealed(64'h0));
    send_item(make_sealed('1));
    send_item(make_decode(64'h0, 16'h0000));
    send_item(make_decode('1, 16'hFFFF));
    it = make_sealed(spread_balance(16'h1234));
    it.check_bytes ^= 16'h0001;                 // bad check byte
    send_item(it);
    it = make_sealed(spread_balance(16'h1234));
    it.data_bytes ^= 64'h8000_0000_0000_0000;   // bad data bit
    send_item(it);
    it = make_sealed(spread_balance(16'h0F0F));
    it.balance = 16'hFFFF;                      // ignored on decode
    send_item(it);
  endtask

  // Receiver holds off while the sender keeps offering: pipeline fills up
  task automatic test_output_hold_off();
    hold_req = 1'b1;
    quiet_tx = 1'b1;
    repeat (24) send_item(random_item());
    quiet_tx = 1'b0;
  endtask

  // Random mix in segments, with and without gaps on either side
  task automatic test_random_traffic();
    for (int seg = 0; seg < 5; seg++) begin
      quiet_tx = (seg == 1 || seg == 3);
      quiet_rx = (seg == 2 || seg == 3);
      repeat (RANDOM_ITEMS / 5) send_item(random_item());
    end
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_req     = 1'b0;
    quiet_tx     = 1'b0;
    quiet_rx     = 1'b0;
    n_fail       = 0;
    n_encode     = 0;
    n_decode     = 0;
    n_good_crc   = 0;
    n_results    = 0;
    n_in_stalled = 0;
    idle_cycles  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_encode_corners();
    test_decode_corners();
    test_output_hold_off();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d encodes and %0d decodes (%0d with a good CRC), %0d beats checked",
             n_encode, n_decode, n_good_crc, n_results);
    $display("Input held back by the block for %0d cycles, %0d mismatches",
             n_in_stalled, n_fail);
    if (n_fail == 0) begin
      $display("** balance_block_codec_crc16_core: PASSED **");
    end else begin
      $display("** balance_block_codec_crc16_core: FAILED **");
    end
    $finish;
  end

endmodule
